### rtl/core/path_table_search_interpolate_core_defines.svh
// Assertion macros shared by the path table core RTL.
`ifndef PATH_TABLE_SEARCH_INTERPOLATE_CORE_DEFINES_SVH
`define PATH_TABLE_SEARCH_INTERPOLATE_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PTSI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PTSI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PTSI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PTSI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/core/ptsi_pkg.sv
// Types and constants of the path table search and interpolation core.
package ptsi_pkg;

  localparam int unsigned MW   = 33;  // serial operand width
  localparam int unsigned AccW = 66;  // accumulator / dividend width
  localparam int unsigned QW   = 34;  // result width of the serial unit
  localparam int unsigned CntW = 7;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_LOC    = 3'd1;
  localparam logic [2:0] OP_LEN    = 3'd2;
  localparam logic [2:0] OP_HGT    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef enum logic [1:0] {
    CMD_MAC,
    CMD_DIV,
    CMD_SQRT
  } arith_cmd_e;

  typedef struct packed {
    logic       start;
    logic       clr;
    arith_cmd_e cmd;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_A_DIF,
    S_A_MAC,
    S_A_SQRT,
    S_Q_FIRST,
    S_Q_LAST,
    S_Q_LOOP,
    S_Q_PROBE,
    S_Q_TOP,
    S_Q_BOT,
    S_L_MUL,
    S_L_DIV,
    S_OUT
  } state_e;

endpackage

### rtl/core/ptsi_ram.sv
// Generic single write, single registered read RAM.
module ptsi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ptsi_arith.sv
// Bit-serial multiply-accumulate, restoring divide and square root unit.
module ptsi_arith (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ptsi_pkg::arith_req_t     req_i,
  input  logic [ptsi_pkg::MW-1:0]  opa_i,
  input  logic [ptsi_pkg::MW-1:0]  opb_i,
  output ptsi_pkg::arith_stat_t    stat_o,
  output logic [ptsi_pkg::QW-1:0]  res_o
);
  import ptsi_pkg::*;

  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  arith_cmd_e      cmd_q, cmd_d;
  logic [AccW-1:0] acc_q, acc_d, bsh_q, bsh_d;
  logic [MW-1:0]   a_q, a_d, d_q, d_d;
  logic [35:0]     rem_q, rem_d;
  logic [31:0]     root_q, root_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic            over_q, over_d;

  always_comb begin
    logic [33:0] r2;
    logic [35:0] s2;
    logic [35:0] trial;
    logic        qbit;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    cmd_d  = cmd_q;
    acc_d  = acc_q;
    bsh_d  = bsh_q;
    a_d    = a_q;
    d_d    = d_q;
    rem_d  = rem_q;
    root_d = root_q;
    quo_d  = quo_q;
    over_d = over_q;
    r2     = {rem_q[32:0], acc_q[AccW-1]};
    s2     = {rem_q[33:0], acc_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    qbit   = (r2 >= {1'b0, d_q});
    if (req_i.start) begin
      busy_d = 1'b1;
      cmd_d  = req_i.cmd;
      a_d    = opa_i;
      bsh_d  = {{(AccW-MW){1'b0}}, opb_i};
      d_d    = opb_i;
      rem_d  = '0;
      root_d = '0;
      quo_d  = '0;
      over_d = 1'b0;
      if (req_i.clr) begin
        acc_d = '0;
      end
      case (req_i.cmd)
        CMD_MAC:  cnt_d = CntW'(MW);
        CMD_DIV:  cnt_d = CntW'(AccW);
        CMD_SQRT: cnt_d = CntW'(32);
        default:  cnt_d = CntW'(1);
      endcase
    end else if (busy_q) begin
      case (cmd_q)
        CMD_MAC: begin
          if (a_q[0]) begin
            acc_d = acc_q + bsh_q;
          end
          a_d   = a_q >> 1;
          bsh_d = bsh_q << 1;
        end
        CMD_DIV: begin
          acc_d = acc_q << 1;
          if (qbit) begin
            rem_d = {2'b00, r2 - {1'b0, d_q}};
          end else begin
            rem_d = {2'b00, r2};
          end
          quo_d  = {quo_q[QW-2:0], qbit};
          // quotient bits at weight 2^33 and up saturate
          over_d = over_q | (qbit && (cnt_q >= CntW'(34)));
        end
        CMD_SQRT: begin
          acc_d = acc_q << 2;
          if (s2 >= trial) begin
            rem_d  = s2 - trial;
            root_d = {root_q[30:0], 1'b1};
          end else begin
            rem_d  = s2;
            root_d = {root_q[30:0], 1'b0};
          end
        end
        default: ;
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    acc_q  <= acc_d;
    bsh_q  <= bsh_d;
    a_q    <= a_d;
    d_q    <= d_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    quo_q  <= quo_d;
    over_q <= over_d;
  end

  always_comb begin
    case (cmd_q)
      CMD_DIV:  res_o = over_q ? {1'b0, 1'b1, {(QW-2){1'b0}}} : {1'b0, quo_q[QW-2:0]};
      CMD_SQRT: res_o = {2'b00, root_q};
      default:  res_o = '0;
    endcase
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

`include "path_table_search_interpolate_core_defines.svh"

  `PTSI_ASSERT_IMP(a_start_idle, clk_i, rst_ni, req_i.start, !busy_q, "start while busy")
  `PTSI_ASSERT_NXT(a_start_busy, clk_i, rst_ni, req_i.start, busy_q, "start not taken")
  `PTSI_ASSERT_NXT(a_done_end, clk_i, rst_ni, busy_q && !req_i.start && (cnt_q == CntW'(1)), done_q && !busy_q, "missing done")

endmodule

### rtl/core/path_table_search_interpolate_core.sv
// Top level of the path table search and interpolation core.
// Usage:
//  - Request channel (in_valid_i/in_ready_o) carries operation_i, a point
//    (in_x_i, in_y_i, in_z_i) for appends and query_key_i for lookups.
//  - Result channel (out_valid_o/out_ready_i) returns one result per request.
//  - One request is worked on at a time; in_ready_o is high only while idle.
//  - Longer operations run on the bit-serial arithmetic unit, one bit per cycle:
//      append: three squares multiply-accumulated, then a square root;
//        first point, full table, saturated delta, clear: no serial arithmetic.
//      queries: a binary search over the table, plus one interpolation,
//        a multiply then a divide (two for a location query).
//  - Points live in four RAMs of MAX_POINTS words with registered read.
//  - Reset empties the table (point count 0); RAM contents are not cleared.
//  - A finished result sits in an output register; the next request can be
//    accepted while it waits. If the receiver stalls, the following result
//    holds in the core until the register frees.
module path_table_search_interpolate_core #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  logic signed [31:0] in_z_i,
  input  logic signed [31:0] query_key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_value_o,
  output logic [1:0]         status_o
);
  import ptsi_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned EW = AW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_POINTS);

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat36(input logic [35:0] v);
    logic signed [35:0] s;
    s = $signed(v);
    if (s > 36'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -36'sh0_8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  // cumulative length, saturating at the positive limit
  function automatic logic signed [31:0] cum_add(input logic [31:0] prev,
                                                 input logic [31:0] len);
    logic [33:0] s;
    s = {{2{prev[31]}}, prev} + {2'b00, len};
    if (!s[33] && (s[32] || s[31])) return 32'sh7FFF_FFFF;
    return s[31:0];
  endfunction

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0] op_q, op_d;
  logic signed [31:0] x_q, x_d, y_q, y_d, z_q, z_d, key_q, key_d;
  logic [AW-1:0] top_q, top_d, bot_q, bot_d, idx_q, idx_d;
  logic signed [31:0] tx_q, tx_d, ty_q, ty_d, tz_q, tz_d, tc_q, tc_d;
  logic signed [31:0] bx_q, bx_d, by_q, by_d, bz_q, bz_d, bc_q, bc_d;
  logic [32:0] dm_q [3];
  logic [32:0] dm_d [3];
  logic [1:0] sq_q, sq_d;
  logic ln_q, ln_d;
  logic [32:0] num_q, num_d, den_q, den_d;
  logic signed [31:0] rx_q, rx_d, ry_q, ry_d, rv_q, rv_d;
  logic [1:0] rs_q, rs_d;
  logic signed [31:0] ox_q, ox_d, oy_q, oy_d, ovl_q, ovl_d;
  logic [1:0] ost_q, ost_d;
  logic ov_q, ov_d;

  // RAM side
  logic ram_we;
  logic [AW-1:0] rd_addr;
  logic signed [31:0] wc;
  logic [31:0] rdx, rdy, rdz, rdc;
  logic signed [31:0] rd_x, rd_y, rd_z, rd_c;

  // serial unit
  arith_req_t areq;
  arith_stat_t ar_stat;
  logic [MW-1:0] ar_a, ar_b;
  logic [QW-1:0] ar_res;

  assign rd_x = $signed(rdx);
  assign rd_y = $signed(rdy);
  assign rd_z = $signed(rdz);
  assign rd_c = $signed(rdc);

  ptsi_ram #(.Width(32), .Depth(MAX_POINTS)) u_ram_x (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(x_q),
    .raddr_i(rd_addr), .rdata_o(rdx)
  );
  ptsi_ram #(.Width(32), .Depth(MAX_POINTS)) u_ram_y (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(y_q),
    .raddr_i(rd_addr), .rdata_o(rdy)
  );
  ptsi_ram #(.Width(32), .Depth(MAX_POINTS)) u_ram_z (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(z_q),
    .raddr_i(rd_addr), .rdata_o(rdz)
  );
  ptsi_ram #(.Width(32), .Depth(MAX_POINTS)) u_ram_c (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(wc),
    .raddr_i(rd_addr), .rdata_o(rdc)
  );

  ptsi_arith u_arith (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(areq), .opa_i(ar_a), .opb_i(ar_b),
    .stat_o(ar_stat), .res_o(ar_res)
  );

  // ---- shared decode ----
  logic is_len, is_loc, full, empty;
  logic hit_first, hit_last, loop_more, go_bot, probe_eq, single;
  logic [AW-1:0] mid, cnt_m1;
  logic [CW-1:0] cnt_m1_w;
  logic [EW-1:0] mid_sum;
  logic signed [31:0] kt, kb;
  logic kequal;
  logic [32:0] numc, denc;
  logic [32:0] dxs, dys, dzs, mx, my, mz;
  logic sat;
  logic signed [31:0] bsx, bsy, bsz, bsc;
  logic [32:0] mvx, mvy, mvc, mvz, mv_cur;
  logic signed [31:0] base_cur, fin;
  logic neg;
  logic [35:0] fsum;

  assign is_len    = (op_q == OP_HGT);
  assign is_loc    = (op_q == OP_LOC);
  assign full      = (cnt_q >= MaxCnt);
  assign empty     = (cnt_q == '0);
  assign cnt_m1_w  = cnt_q - 1'b1;
  assign cnt_m1    = cnt_m1_w[AW-1:0];
  assign hit_first = is_len ? (key_q <= rd_c) : (key_q >= rd_z);
  assign hit_last  = is_len ? (key_q >= rd_c) : (key_q <= rd_z);
  assign loop_more = (({1'b0, top_q} + 1'b1) < {1'b0, bot_q});
  assign mid_sum   = {1'b0, top_q} + {1'b0, bot_q};
  assign mid       = mid_sum[AW:1];
  assign go_bot    = is_len ? (rd_c > key_q) : (rd_z < key_q);
  assign probe_eq  = is_len && (rd_c == key_q);
  assign single    = (({1'b0, idx_q} + 1'b1) >= EW'(cnt_q));
  assign kt        = is_len ? tc_q : tz_q;
  assign kb        = is_len ? rd_c : rd_z;
  assign kequal    = (kt == kb);
  assign numc      = {key_q[31], key_q} - {kb[31], kb};
  assign denc      = {kt[31], kt} - {kb[31], kb};

  // append deltas against the previous point
  assign dxs = {x_q[31], x_q} - {rd_x[31], rd_x};
  assign dys = {y_q[31], y_q} - {rd_y[31], rd_y};
  assign dzs = {z_q[31], z_q} - {rd_z[31], rd_z};
  assign mx  = mag33(dxs);
  assign my  = mag33(dys);
  assign mz  = mag33(dzs);
  assign sat = mx[32] | mx[31] | my[32] | my[31] | mz[32] | mz[31];

  // lower interval end comes straight from RAM in the cycle it arrives
  assign bsx = (state_q == S_Q_BOT) ? rd_x : bx_q;
  assign bsy = (state_q == S_Q_BOT) ? rd_y : by_q;
  assign bsz = (state_q == S_Q_BOT) ? rd_z : bz_q;
  assign bsc = (state_q == S_Q_BOT) ? rd_c : bc_q;
  assign mvx = {tx_q[31], tx_q} - {bsx[31], bsx};
  assign mvy = {ty_q[31], ty_q} - {bsy[31], bsy};
  assign mvc = {tc_q[31], tc_q} - {bsc[31], bsc};
  assign mvz = {tz_q[31], tz_q} - {bsz[31], bsz};

  always_comb begin
    case (op_q)
      OP_LOC: begin
        mv_cur   = ln_q ? mvy : mvx;
        base_cur = ln_q ? bsy : bsx;
      end
      OP_LEN: begin
        mv_cur   = mvc;
        base_cur = bsc;
      end
      default: begin
        mv_cur   = mvz;
        base_cur = bsz;
      end
    endcase
  end

  // base +/- saturated quotient
  assign neg  = num_q[32] ^ mv_cur[32] ^ den_q[32];
  assign fsum = neg ? ({{4{base_cur[31]}}, base_cur} - {2'b00, ar_res})
                    : ({{4{base_cur[31]}}, base_cur} + {2'b00, ar_res});
  assign fin  = sat36(fsum);

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DEC;
      S_DEC: begin
        case (op_q)
          OP_APPEND: state_d = (full || empty) ? S_OUT : S_A_DIF;
          OP_LOC, OP_LEN, OP_HGT: state_d = empty ? S_OUT : S_Q_FIRST;
          default: state_d = S_OUT;
        endcase
      end
      S_A_DIF:   state_d = sat ? S_OUT : S_A_MAC;
      S_A_MAC:   if (ar_stat.done && (sq_q == 2'd3)) state_d = S_A_SQRT;
      S_A_SQRT:  if (ar_stat.done) state_d = S_OUT;
      S_Q_FIRST: state_d = hit_first ? S_Q_TOP : S_Q_LAST;
      S_Q_LAST:  state_d = hit_last ? S_Q_TOP : S_Q_LOOP;
      S_Q_LOOP:  state_d = loop_more ? S_Q_PROBE : S_Q_TOP;
      S_Q_PROBE: state_d = probe_eq ? S_Q_TOP : S_Q_LOOP;
      S_Q_TOP:   state_d = single ? S_OUT : S_Q_BOT;
      S_Q_BOT:   state_d = kequal ? S_OUT : S_L_MUL;
      S_L_MUL:   if (ar_stat.done) state_d = S_L_DIV;
      S_L_DIV: begin
        if (ar_stat.done) state_d = (is_loc && !ln_q) ? S_L_MUL : S_OUT;
      end
      S_OUT:     if (!ov_q || out_ready_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // ---- datapath and outputs ----
  always_comb begin
    cnt_d = cnt_q;   op_d = op_q;   x_d = x_q;   y_d = y_q;   z_d = z_q;
    key_d = key_q;   top_d = top_q; bot_d = bot_q; idx_d = idx_q;
    tx_d = tx_q; ty_d = ty_q; tz_d = tz_q; tc_d = tc_q;
    bx_d = bx_q; by_d = by_q; bz_d = bz_q; bc_d = bc_q;
    dm_d = dm_q; sq_d = sq_q; ln_d = ln_q; num_d = num_q; den_d = den_q;
    rx_d = rx_q; ry_d = ry_q; rv_d = rv_q; rs_d = rs_q;
    ox_d = ox_q; oy_d = oy_q; ovl_d = ovl_q; ost_d = ost_q;
    ov_d = ov_q;
    in_ready_o = 1'b0;
    ram_we  = 1'b0;
    wc      = '0;
    rd_addr = '0;
    areq    = '{start: 1'b0, clr: 1'b0, cmd: CMD_MAC};
    ar_a    = '0;
    ar_b    = '0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = operation_i;
          x_d   = in_x_i;
          y_d   = in_y_i;
          z_d   = in_z_i;
          key_d = query_key_i;
        end
      end
      S_DEC: begin
        rx_d = '0; ry_d = '0; rv_d = '0; rs_d = ST_OK;
        // location lerp starts on x
        ln_d = 1'b0;
        case (op_q)
          OP_APPEND: begin
            if (full) begin
              rs_d = ST_FULL;
            end else if (empty) begin
              ram_we = 1'b1;
              wc     = '0;
              cnt_d  = cnt_q + 1'b1;
            end else begin
              rd_addr = cnt_m1;
            end
          end
          OP_LOC, OP_LEN, OP_HGT: begin
            if (empty) rs_d = ST_EMPTY;
            else rd_addr = '0;
          end
          OP_CLEAR: cnt_d = '0;
          default: ;
        endcase
      end
      S_A_DIF: begin
        tc_d  = rd_c;
        dm_d[0] = mx;
        dm_d[1] = my;
        dm_d[2] = mz;
        if (sat) begin
          wc     = cum_add(rd_c, 32'h7FFF_FFFF);
          ram_we = 1'b1;
          rv_d   = wc;
          cnt_d  = cnt_q + 1'b1;
        end else begin
          areq = '{start: 1'b1, clr: 1'b1, cmd: CMD_MAC};
          ar_a = mx;
          ar_b = mx;
          sq_d = 2'd1;
        end
      end
      S_A_MAC: begin
        if (ar_stat.done) begin
          case (sq_q)
            2'd1: begin
              areq = '{start: 1'b1, clr: 1'b0, cmd: CMD_MAC};
              ar_a = dm_q[1];
              ar_b = dm_q[1];
              sq_d = 2'd2;
            end
            2'd2: begin
              areq = '{start: 1'b1, clr: 1'b0, cmd: CMD_MAC};
              ar_a = dm_q[2];
              ar_b = dm_q[2];
              sq_d = 2'd3;
            end
            default: areq = '{start: 1'b1, clr: 1'b0, cmd: CMD_SQRT};
          endcase
        end
      end
      S_A_SQRT: begin
        if (ar_stat.done) begin
          wc     = cum_add(tc_q, ar_res[31:0]);
          ram_we = 1'b1;
          rv_d   = wc;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      S_Q_FIRST: begin
        top_d = '0;
        bot_d = cnt_m1;
        if (hit_first) begin
          idx_d   = '0;
          rd_addr = '0;
        end else begin
          rd_addr = cnt_m1;
        end
      end
      S_Q_LAST: begin
        if (hit_last) begin
          idx_d   = bot_q;
          rd_addr = bot_q;
        end
      end
      S_Q_LOOP: begin
        if (loop_more) begin
          idx_d   = mid;
          rd_addr = mid;
        end else begin
          idx_d   = top_q;
          rd_addr = top_q;
        end
      end
      S_Q_PROBE: begin
        if (probe_eq) begin
          rd_addr = idx_q;
        end else if (go_bot) begin
          bot_d = idx_q;
        end else begin
          top_d = idx_q;
        end
      end
      S_Q_TOP: begin
        tx_d = rd_x; ty_d = rd_y; tz_d = rd_z; tc_d = rd_c;
        if (single) begin
          if (is_loc) begin
            rx_d = rd_x;
            ry_d = rd_y;
          end else begin
            rv_d = is_len ? rd_z : rd_c;
          end
        end else begin
          rd_addr = idx_q + 1'b1;
        end
      end
      S_Q_BOT: begin
        bx_d = rd_x; by_d = rd_y; bz_d = rd_z; bc_d = rd_c;
        num_d = numc;
        den_d = denc;
        ln_d  = 1'b0;
        if (kequal) begin
          rs_d = ST_ZERO;
          if (is_loc) begin
            rx_d = tx_q;
            ry_d = ty_q;
          end else begin
            rv_d = is_len ? tz_q : tc_q;
          end
        end else begin
          areq = '{start: 1'b1, clr: 1'b1, cmd: CMD_MAC};
          ar_a = mag33(numc);
          ar_b = mag33(mv_cur);
        end
      end
      S_L_MUL: begin
        if (ar_stat.done) begin
          areq = '{start: 1'b1, clr: 1'b0, cmd: CMD_DIV};
          ar_b = mag33(den_q);
        end
      end
      S_L_DIV: begin
        if (ar_stat.done) begin
          if (is_loc && !ln_q) begin
            rx_d = fin;
            ln_d = 1'b1;
            areq = '{start: 1'b1, clr: 1'b1, cmd: CMD_MAC};
            ar_a = mag33(num_q);
            ar_b = mag33(mvy);
          end else if (is_loc) begin
            ry_d = fin;
          end else begin
            rv_d = fin;
          end
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ox_d  = rx_q;
          oy_d  = ry_q;
          ovl_d = rv_q;
          ost_d = rs_q;
          ov_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; x_q <= x_d; y_q <= y_d; z_q <= z_d; key_q <= key_d;
    top_q <= top_d; bot_q <= bot_d; idx_q <= idx_d;
    tx_q <= tx_d; ty_q <= ty_d; tz_q <= tz_d; tc_q <= tc_d;
    bx_q <= bx_d; by_q <= by_d; bz_q <= bz_d; bc_q <= bc_d;
    dm_q <= dm_d; sq_q <= sq_d; ln_q <= ln_d; num_q <= num_d; den_q <= den_d;
    rx_q <= rx_d; ry_q <= ry_d; rv_q <= rv_d; rs_q <= rs_d;
    ox_q <= ox_d; oy_q <= oy_d; ovl_q <= ovl_d; ost_q <= ost_d;
  end

  assign out_valid_o = ov_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_value_o = ovl_q;
  assign status_o    = ost_q;

`include "path_table_search_interpolate_core_defines.svh"

  `PTSI_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= MaxCnt, "point count above table size")
  `PTSI_ASSERT_IMP(a_we_room, clk_i, rst_ni, ram_we, cnt_q < MaxCnt, "append into full table")
  `PTSI_ASSERT_IMP(a_done_wait, clk_i, rst_ni, ar_stat.done, (state_q == S_A_MAC) || (state_q == S_A_SQRT) || (state_q == S_L_MUL) || (state_q == S_L_DIV), "serial unit done outside a wait state")

endmodule

### bench/tb.sv
// Self-checking bench for the path table search and interpolation core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptsi_pkg::*;

  localparam int unsigned NPTS = 1024;
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  // how a query key is filled in when the request is loaded
  typedef enum logic [1:0] {KEY_RAW, KEY_LEN_OF, KEY_HGT_OF} key_src_e;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] x, y, z, key;
    key_src_e           src;
    int unsigned        idx;
  } path_req_t;

  typedef struct {
    logic signed [31:0] x, y, v;
    logic [1:0]         st;
  } path_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] operation = OP_CLEAR;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0, query_key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_value;
  logic [1:0] status;

  path_req_t pending_reqs[$];
  path_res_t expected_res[$];
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;

  // shadow copy of the point table
  logic signed [31:0] tbl_x[NPTS], tbl_y[NPTS], tbl_z[NPTS], tbl_len[NPTS];
  int unsigned tbl_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  path_table_search_interpolate_core #(.MAX_POINTS(NPTS)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .in_x_i(in_x), .in_y_i(in_y), .in_z_i(in_z),
    .query_key_i(query_key),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_x_o(out_x), .out_y_o(out_y), .out_value_o(out_value), .status_o(status)
  );

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // base + trunc(num*mul/den), fraction capped at 2^40, result saturated
  function automatic logic signed [31:0] interp(longint base, longint num, longint mul,
                                                longint den);
    logic [63:0] a, b, d;
    logic [127:0] prod, q;
    logic neg;
    longint frac;
    a = magnitude(num);
    b = magnitude(mul);
    d = magnitude(den);
    neg = ((num < 0) != (mul < 0)) && a != 0 && b != 0;
    if (den < 0) neg = !neg;
    prod = {64'd0, a} * {64'd0, b};
    q = prod / {64'd0, d};
    if (q >= (128'd1 << 40)) q = 128'd1 << 40;
    frac = longint'(q[63:0]);
    return sat32(neg ? base - frac : base + frac);
  endfunction

  function automatic int unsigned search_height(longint key);
    int unsigned lo, hi, m;
    lo = 0;
    hi = tbl_cnt - 1;
    if (key >= tbl_z[0]) return 0;
    if (key <= tbl_z[hi]) return hi;
    while (lo + 1 < hi) begin
      m = (lo + hi) / 2;
      if (tbl_z[m] < key) hi = m;
      else lo = m;
    end
    return lo;
  endfunction

  function automatic int unsigned search_length(longint key);
    int unsigned lo, hi, m;
    lo = 0;
    hi = tbl_cnt - 1;
    if (key <= tbl_len[0]) return 0;
    if (key >= tbl_len[hi]) return hi;
    while (lo + 1 < hi) begin
      m = (lo + hi) / 2;
      if (tbl_len[m] > key) hi = m;
      else if (tbl_len[m] < key) lo = m;
      else return m; // exact length match selects that entry
    end
    return lo;
  endfunction

  // updates the shadow table and returns the result a request produces
  function automatic path_res_t predict_path(path_req_t r);
    path_res_t res;
    int unsigned n, i;
    logic [63:0] dx, dy, dz, seg;
    longint kt, kb, cum;
    res = '{x: '0, y: '0, v: '0, st: ST_OK};
    if (r.op == OP_APPEND) begin
      if (tbl_cnt >= NPTS) begin
        res.st = ST_FULL;
      end else begin
        n = tbl_cnt;
        cum = 0;
        if (n > 0) begin
          dx = magnitude(longint'(r.x) - tbl_x[n-1]);
          dy = magnitude(longint'(r.y) - tbl_y[n-1]);
          dz = magnitude(longint'(r.z) - tbl_z[n-1]);
          if (dx >= 64'h80000000 || dy >= 64'h80000000 || dz >= 64'h80000000)
            seg = 64'h7FFFFFFF;
          else
            seg = int_sqrt(dx * dx + dy * dy + dz * dz);
          cum = sat32(longint'(tbl_len[n-1]) + longint'(seg));
        end
        tbl_x[n] = r.x;
        tbl_y[n] = r.y;
        tbl_z[n] = r.z;
        tbl_len[n] = cum[31:0];
        tbl_cnt = n + 1;
        res.v = cum[31:0];
      end
    end else if (r.op == OP_LOC || r.op == OP_LEN || r.op == OP_HGT) begin
      if (tbl_cnt == 0) begin
        res.st = ST_EMPTY;
      end else begin
        i = (r.op == OP_HGT) ? search_length(r.key) : search_height(r.key);
        if (i + 1 >= tbl_cnt) begin
          res.x = tbl_x[i];
          res.y = tbl_y[i];
          res.v = (r.op == OP_HGT) ? tbl_z[i] : tbl_len[i];
        end else begin
          kt = (r.op == OP_HGT) ? tbl_len[i] : tbl_z[i];
          kb = (r.op == OP_HGT) ? tbl_len[i+1] : tbl_z[i+1];
          if (kt == kb) begin
            res.st = ST_ZERO;
            res.x = tbl_x[i];
            res.y = tbl_y[i];
            res.v = (r.op == OP_HGT) ? tbl_z[i] : tbl_len[i];
          end else if (r.op == OP_LOC) begin
            res.x = interp(tbl_x[i+1], r.key - kb, longint'(tbl_x[i]) - tbl_x[i+1], kt - kb);
            res.y = interp(tbl_y[i+1], r.key - kb, longint'(tbl_y[i]) - tbl_y[i+1], kt - kb);
          end else if (r.op == OP_LEN) begin
            res.v = interp(tbl_len[i+1], r.key - kb,
                           longint'(tbl_len[i]) - tbl_len[i+1], kt - kb);
          end else begin
            res.v = interp(tbl_z[i+1], r.key - kb,
                           longint'(tbl_z[i]) - tbl_z[i+1], kt - kb);
          end
        end
        if (r.op != OP_LOC) begin
          res.x = '0;
          res.y = '0;
        end else begin
          res.v = '0;
        end
      end
    end else if (r.op == OP_CLEAR) begin
      tbl_cnt = 0;
    end
    return res;
  endfunction

  // idle with a 37 percent chance, except for a stretch mid-run that never idles
  function automatic bit idle_now();
    if (n_accepted >= 200 && n_accepted < 400) return 1'b0;
    return $urandom_range(99) < 37;
  endfunction

  // driver: one request at a time from the pending queue
  always @(posedge clk or negedge rst_n) begin
    path_req_t r;
    bit take, nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      nv = in_valid && !take;
      if (take) begin
        r.op = operation;
        r.x = in_x;
        r.y = in_y;
        r.z = in_z;
        r.key = query_key;
        r.src = KEY_RAW;
        r.idx = 0;
        expected_res.insert(expected_res.size(), predict_path(r));
        n_accepted++;
      end
      if (!nv && pending_reqs.size() > 0 && !idle_now()) begin
        r = pending_reqs.pop_front();
        // resolve keys that hit a stored entry exactly
        if (r.src != KEY_RAW && tbl_cnt > 0)
          r.key = (r.src == KEY_LEN_OF) ? tbl_len[r.idx % tbl_cnt] : tbl_z[r.idx % tbl_cnt];
        operation <= r.op;
        in_x <= r.x;
        in_y <= r.y;
        in_z <= r.z;
        query_key <= r.key;
        nv = 1'b1;
      end
      in_valid <= nv;
    end
  end

  // monitor: random backpressure and field-by-field compare
  always @(posedge clk or negedge rst_n) begin
    path_res_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d v=%0d st=%0d",
                   $time, out_x, out_y, out_value, status);
          n_errors++;
        end else begin
          e = expected_res.pop_front();
          if (out_x !== e.x) begin
            $display("%0t: out_x expected %0d actual %0d", $time, e.x, out_x);
            n_errors++;
          end
          if (out_y !== e.y) begin
            $display("%0t: out_y expected %0d actual %0d", $time, e.y, out_y);
            n_errors++;
          end
          if (out_value !== e.v) begin
            $display("%0t: out_value expected %0d actual %0d", $time, e.v, out_value);
            n_errors++;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            n_errors++;
          end
        end
      end
      out_ready <= !idle_now();
    end
  end

  task automatic push_req(logic [2:0] op, logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] z, logic signed [31:0] key,
                          key_src_e src = KEY_RAW, int unsigned idx = 0);
    path_req_t r;
    r.op = op;
    r.x = x;
    r.y = y;
    r.z = z;
    r.key = key;
    r.src = src;
    r.idx = idx;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_query(logic [2:0] op, logic signed [31:0] key);
    push_req(op, $urandom, $urandom, $urandom, key);
  endtask

  // descending path; wild mode uses full-range unordered points
  task automatic build_path(int unsigned n, bit wild, output longint zhi, output longint zlo,
                            output longint span);
    longint z, x, y;
    int unsigned step;
    z = longint'($urandom_range(200000)) - 50000;
    x = longint'($urandom_range(20000)) - 10000;
    y = longint'($urandom_range(20000)) - 10000;
    zhi = z;
    span = 0;
    for (int unsigned k = 0; k < n; k++) begin
      if (wild) begin
        push_req(OP_APPEND, $urandom, $urandom, $urandom, $urandom);
      end else begin
        push_req(OP_APPEND, x[31:0], y[31:0], z[31:0], $urandom);
        step = ($urandom_range(9) == 0) ? 0 : $urandom_range(3000);
        z = z - step;
        x = x + longint'($urandom_range(4000)) - 2000;
        y = y + longint'($urandom_range(4000)) - 2000;
        span = span + 3 * step + 6000;
      end
    end
    zlo = z;
  endtask

  task automatic query_mix(int unsigned n, longint zhi, longint zlo, longint span);
    int unsigned kind;
    longint key;
    for (int unsigned k = 0; k < n; k++) begin
      kind = $urandom_range(9);
      key = zlo - 3000 + longint'($urandom_range(int'(zhi - zlo) + 6000));
      case (kind)
        0: push_query(OP_LOC, $urandom);
        1: push_query(OP_HGT, $urandom);
        2: push_req(OP_HGT, $urandom, $urandom, $urandom, '0, KEY_LEN_OF, $urandom);
        3: push_req(OP_LOC, $urandom, $urandom, $urandom, '0, KEY_HGT_OF, $urandom);
        4: push_req(OP_LEN, $urandom, $urandom, $urandom, '0, KEY_HGT_OF, $urandom);
        5: push_query(OP_HGT, 32'(longint'($urandom_range(int'(span) + 4000)) - 2000));
        6: push_query(OP_LEN, key[31:0]);
        default: push_query(OP_LOC, key[31:0]);
      endcase
    end
  endtask

  initial begin
    longint zhi, zlo, span;
    // directed: empty table, single point, extremes, flat interval, bad ops
    push_req(OP_CLEAR, '0, '0, '0, '0);
    push_query(OP_LOC, 32'sd0);
    push_query(OP_LEN, 32'sh7FFFFFFF);
    push_query(OP_HGT, 32'sh80000000);
    push_req(OP_APPEND, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, '0);
    push_query(OP_LOC, 32'sd5);
    push_query(OP_HGT, 32'sd5);
    push_req(OP_APPEND, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, '0);
    push_req(OP_APPEND, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, '0);
    push_query(OP_LOC, 32'sh7FFFFFFF);
    push_query(OP_LEN, 32'sh80000000);
    push_query(OP_LOC, 32'sd0);
    push_query(OP_HGT, 32'sh7FFFFFFF);
    push_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
    push_req(OP_APPEND, 32'sd100, 32'sd100, 32'sd1000, '0);
    push_req(OP_APPEND, 32'sd300, -32'sd50, 32'sd1000, '0);
    push_req(OP_APPEND, 32'sd400, 32'sd50, 32'sd200, '0);
    push_query(OP_LOC, 32'sd1000);
    push_query(OP_LEN, 32'sd600);
    push_query(OP_HGT, 32'sd200);
    push_req(OP_HGT, '0, '0, '0, '0, KEY_LEN_OF, 1);
    push_req(OP_BAD_LO, $urandom, $urandom, $urandom, $urandom);
    push_req(OP_BAD_HI, $urandom, $urandom, $urandom, $urandom);
    push_query(OP_LOC, 32'sd2000);

    // random: mostly well-formed tables then queries, some wild tables
    for (int unsigned round = 0; round < 40; round++) begin
      push_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      build_path($urandom_range(12, 1), $urandom_range(5) == 0, zhi, zlo, span);
      query_mix($urandom_range(14, 4), zhi, zlo, span);
      if ($urandom_range(4) == 0)
        push_req(3'($urandom_range(OP_BAD_HI, OP_BAD_LO)), $urandom, $urandom, $urandom,
                 $urandom);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_res.size() == 0);
    repeat (400) @(posedge clk);
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Verification failed");
    $finish;
  end
endmodule
